// ===== rtl/cdq_pkg.sv =====
// Shared types, constants and ring arithmetic for the circular deque core.
`default_nettype none
package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int KEY_W  = 32;
  localparam int REC_W  = 32;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_M1  = CNT_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SEARCH     = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_TAIL,
    ST_SCAN
  } state_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_TAIL,
    RD_SCAN
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    clear;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    scan_clr;
    logic    scan_inc;
    logic    resp;
    status_t resp_status;
    logic    resp_rec;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       empty;
    logic       full;
    logic       one_left;
    logic       hit;
    logic       scan_done;
  } sts_t;

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [CNT_W-1:0]  b);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cdq_datapath.sv =====
// Datapath of the circular deque: ring storage, head and fill count, scan and response.
`default_nettype none
module cdq_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cdq_pkg::cmd_t              cmd,
  input  wire logic [2:0]                 action,
  input  wire logic [cdq_pkg::KEY_W-1:0]  key,
  input  wire logic [cdq_pkg::REC_W-1:0]  record,
  output cdq_pkg::sts_t                   sts,
  output logic                            done,
  output logic [cdq_pkg::REC_W-1:0]       result_record,
  output logic [1:0]                      status,
  output logic [cdq_pkg::CNT_W-1:0]       entries_held
);
  import cdq_pkg::*;

  logic [KEY_W-1:0]  key_mem [DEPTH];
  logic [REC_W-1:0]  rec_mem [DEPTH];

  logic [2:0]        act_q;
  logic [KEY_W-1:0]  key_q;
  logic [REC_W-1:0]  rec_q;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] head_next;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;
  logic [SLOT_W-1:0] offset;
  logic [KEY_W-1:0]  rd_key;
  logic [REC_W-1:0]  rd_rec;
  logic [SLOT_W-1:0] wr_addr;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] head_dec;
  logic [SLOT_W-1:0] head_inc;
  logic [SLOT_W-1:0] tail_slot;
  logic [CNT_W-1:0]  offset_p1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= action;
      key_q <= key;
      rec_q <= record;
    end
  end

  assign head_dec  = slot_add(head, DEPTH_M1);
  assign head_inc  = slot_add(head, CNT_W'(1));
  assign tail_slot = slot_add(head, fill - CNT_W'(1));
  assign wr_addr   = cmd.push_front ? head_dec : slot_add(head, fill);
  assign offset_p1 = CNT_W'(offset) + CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD: rd_addr = head;
      RD_TAIL: rd_addr = tail_slot;
      RD_SCAN: rd_addr = slot_add(head, CNT_W'(offset));
      default: rd_addr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.push_front || cmd.push_back) begin
      key_mem[wr_addr] <= key_q;
      rec_mem[wr_addr] <= rec_q;
    end
    if (cmd.rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_rec <= rec_mem[rd_addr];
    end
  end

  always_comb begin
    head_next = head;
    fill_next = fill;
    if (cmd.clear) begin
      head_next = '0;
      fill_next = '0;
    end else if (cmd.push_front) begin
      head_next = head_dec;
      fill_next = fill + CNT_W'(1);
    end else if (cmd.push_back) begin
      fill_next = fill + CNT_W'(1);
    end else if (cmd.pop_front) begin
      head_next = head_inc;
      fill_next = fill - CNT_W'(1);
    end else if (cmd.pop_back) begin
      fill_next = fill - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      offset <= '0;
    end else if (cmd.scan_inc) begin
      offset <= offset + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      result_record <= cmd.resp_rec ? rd_rec : '0;
      status        <= cmd.resp_status;
      entries_held  <= fill_next;
    end
  end

  assign sts.act       = act_q;
  assign sts.empty     = (fill == '0);
  assign sts.full      = (fill == DEPTH_CNT);
  assign sts.one_left  = (fill == CNT_W'(1));
  assign sts.hit       = (rd_key == key_q);
  assign sts.scan_done = (offset_p1 == fill);

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_CNT)
    else $error("fill count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_front || cmd.push_back) |-> fill != DEPTH_CNT)
    else $error("push on full ring");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_front || cmd.pop_back) |-> fill != '0)
    else $error("pop on empty ring");

  a_clear_resets: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (fill == '0) && (head == '0))
    else $error("clear left entries");

endmodule
`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
// Controller state machine of the circular deque: sequences pops, scans and responses.
`default_nettype none
module cdq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire cdq_pkg::sts_t  sts,
  output logic                busy,
  output cdq_pkg::cmd_t       cmd
);
  import cdq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        cmd.resp   = 1'b1;
        case (sts.act)
          ACT_PUSH_FRONT: begin
            if (sts.full) cmd.resp_status = STS_FULL;
            else cmd.push_front = 1'b1;
          end
          ACT_PUSH_BACK: begin
            if (sts.full) cmd.resp_status = STS_FULL;
            else cmd.push_back = 1'b1;
          end
          ACT_POP_FRONT, ACT_POP_BACK: begin
            if (sts.empty) begin
              cmd.resp_status = STS_EMPTY;
            end else begin
              cmd.resp   = 1'b0;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = (sts.act == ACT_POP_FRONT) ? RD_HEAD : RD_TAIL;
              state_next = ST_POP;
            end
          end
          ACT_SEARCH: begin
            if (sts.empty) begin
              cmd.resp_status = STS_EMPTY;
            end else begin
              cmd.resp     = 1'b0;
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = RD_TAIL;
              cmd.scan_clr = 1'b1;
              state_next   = ST_TAIL;
            end
          end
          ACT_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_POP: begin
        cmd.resp     = 1'b1;
        cmd.resp_rec = 1'b1;
        if (sts.act == ACT_POP_FRONT) cmd.pop_front = 1'b1;
        else cmd.pop_back = 1'b1;
        state_next = ST_IDLE;
      end
      ST_TAIL, ST_SCAN: begin
        if (sts.hit) begin
          cmd.resp     = 1'b1;
          cmd.resp_rec = 1'b1;
          state_next   = ST_IDLE;
        end else if ((state == ST_TAIL) ? sts.one_left : sts.scan_done) begin
          cmd.resp        = 1'b1;
          cmd.resp_status = STS_NOT_FOUND;
          state_next      = ST_IDLE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_SCAN;
          cmd.scan_inc = 1'b1;
          state_next   = ST_SCAN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_resp_ends_request: assert property (@(posedge clk) disable iff (rst)
    cmd.resp |=> state == ST_IDLE)
    else $error("response without return to idle");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == ST_IDLE && !busy)
    else $error("request taken while busy");

  a_single_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.resp |=> !cmd.resp)
    else $error("two responses in a row");

endmodule
`default_nettype wire

// ===== rtl/circular_deque_with_key_search_core.sv =====
// Top level of the circular deque with key search: controller plus datapath.
// A request is taken at an edge with start high and busy low; done is a registered response:
// push, clear and error requests answer from the execute state, pops and a tail hit after
// one ring read, and a search that scans the whole ring after its reads, one read per cycle.
// busy drops in the done cycle, so the next request is taken at the edge ending it.
// Receiver cannot stall; synchronous reset empties the list and sets the head slot to zero.
`default_nettype none
module circular_deque_with_key_search_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [2:0]                 action,
  input  wire logic [cdq_pkg::KEY_W-1:0]  key,
  input  wire logic [cdq_pkg::REC_W-1:0]  record,
  output logic                            done,
  output logic [cdq_pkg::REC_W-1:0]       result_record,
  output logic [1:0]                      status,
  output logic [cdq_pkg::CNT_W-1:0]       entries_held
);
  import cdq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  cdq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (action),
    .key           (key),
    .record        (record),
    .sts           (sts),
    .done          (done),
    .result_record (result_record),
    .status        (status),
    .entries_held  (entries_held)
  );

endmodule
`default_nettype wire
